>>> rtl/grid_max_path_score_counter_assert.svh
// Assertion macros for the grid maximum-score path counter.
// Included by the top level; the checks compile away when SYNTHESIS is defined.
// Both macros use the clock clk; the first one also uses the reset rst_n.
`ifndef GRID_MAX_PATH_SCORE_COUNTER_ASSERT_SVH
`define GRID_MAX_PATH_SCORE_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define GMPSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GMPSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMPSC_ASSERT(label, prop, msg)
`define GMPSC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> rtl/gmpsc_pkg.sv
// Shared types and constants for the grid maximum-score path counter.
// Used by the line buffer, the cell update logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gmpsc_pkg;

  localparam int ScoreW = 12;
  localparam int CountW = 30;
  localparam int DimW = 8;
  localparam int DefaultMaxRows = 128;
  localparam int DefaultMaxCols = 128;
  localparam logic [CountW-1:0] CountMod = CountW'(1000000007);

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegGridRows = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGridCols = 1'b1;

  localparam logic [DimW-1:0] GridRowsReset = 8'd2;
  localparam logic [DimW-1:0] GridColsReset = 8'd2;

  // Best score, path count and reachability of one cell.
  typedef struct packed {
    logic              reach;
    logic [ScoreW-1:0] score;
    logic [CountW-1:0] count;
  } nb_t;

  localparam int NbW = $bits(nb_t);

  // Position flags of one cell on the board.
  typedef struct packed {
    logic first;
    logic r_gt0;
    logic c_gt0;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

>>> rtl/gmpsc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gmpsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/gmpsc_linebuf.sv
// Line buffer holding the results of the row below, one entry per column.
// Built on gmpsc_ram; forwards a write that hits the address read in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module gmpsc_linebuf #(
  parameter int Depth = gmpsc_pkg::DefaultMaxCols
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire gmpsc_pkg::nb_t           wr_data,
  output gmpsc_pkg::nb_t                rd_data
);

  logic [gmpsc_pkg::NbW-1:0] ram_rdata;
  logic                      byp_sel_r;
  logic                      byp_sel_nxt;
  gmpsc_pkg::nb_t            byp_data_r;

  gmpsc_ram #(
    .Width(gmpsc_pkg::NbW),
    .Depth(Depth)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    byp_sel_nxt = byp_sel_r;
    if (rd_en) begin
      byp_sel_nxt = wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_sel_r <= 1'b0;
    end else begin
      byp_sel_r <= byp_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_sel_r ? byp_data_r : gmpsc_pkg::nb_t'(ram_rdata);

endmodule

`default_nettype wire

>>> rtl/gmpsc_cell.sv
// Update of one cell: best score over the reachable neighbors plus the cell value,
// and the path count summed over the tying neighbors modulo 1000000007. Uses gmpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmpsc_cell (
  input  wire gmpsc_pkg::tag_t        tag,
  input  wire logic [3:0]             cell_value,
  input  wire logic                   blocked,
  input  wire gmpsc_pkg::nb_t         below,
  input  wire gmpsc_pkg::nb_t         right,
  input  wire gmpsc_pkg::nb_t         diag,
  output gmpsc_pkg::nb_t              res
);

  localparam logic [31:0] Mod1 = 32'(gmpsc_pkg::CountMod);
  localparam logic [31:0] Mod2 = 32'(gmpsc_pkg::CountMod) * 32'd2;

  logic                           bv;
  logic                           rv;
  logic                           dv;
  logic                           have;
  logic [gmpsc_pkg::ScoreW-1:0]   best;
  logic [31:0]                    sum;
  logic [gmpsc_pkg::CountW-1:0]   cnt;

  assign bv = tag.r_gt0 && below.reach;
  assign rv = tag.c_gt0 && right.reach;
  assign dv = tag.r_gt0 && tag.c_gt0 && diag.reach;

  always_comb begin
    have = bv;
    best = below.score;
    if (rv && (!have || right.score > best)) begin
      have = 1'b1;
      best = right.score;
    end
    if (dv && (!have || diag.score > best)) begin
      have = 1'b1;
      best = diag.score;
    end
  end

  always_comb begin
    sum = '0;
    if (bv && below.score == best) begin
      sum = sum + 32'(below.count);
    end
    if (rv && right.score == best) begin
      sum = sum + 32'(right.count);
    end
    if (dv && diag.score == best) begin
      sum = sum + 32'(diag.count);
    end
    if (sum >= Mod2) begin
      sum = sum - Mod2;
    end else if (sum >= Mod1) begin
      sum = sum - Mod1;
    end
    cnt = sum[gmpsc_pkg::CountW-1:0];
  end

  always_comb begin
    if (tag.first) begin
      res.reach = !blocked;
      res.score = blocked ? '0 : gmpsc_pkg::ScoreW'(cell_value);
      res.count = blocked ? '0 : gmpsc_pkg::CountW'(1);
    end else if (have && !blocked) begin
      res.reach = 1'b1;
      res.score = best + gmpsc_pkg::ScoreW'(cell_value);
      res.count = cnt;
    end else begin
      res.reach = 1'b0;
      res.score = '0;
      res.count = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/grid_max_path_score_counter.sv
// Top level of the grid maximum-score path counter: position counters, input stage,
// right and diagonal neighbor registers and result register. Uses gmpsc_pkg,
// gmpsc_linebuf, gmpsc_cell and the assertion macros.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[3:0] cell_value, tuser[0] blocked
//   out_     master     tdata[11:0] best_score, tdata[41:12] path_count
//   cfg_     write      index 0 grid_rows, index 1 grid_cols, data 8 bits
//
// One cell is accepted per cycle unless the input stalls; the line buffer read is issued at
// acceptance and the cell update runs in the following cycle, registering any end cell's result.
// Input requests stall only while the end cell waits for a full, unread result register.
// Reset is synchronous and active low; the line buffer needs no clearing.
// A configuration write restarts the board at the start cell.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_max_path_score_counter_assert.svh"

module grid_max_path_score_counter #(
  parameter int MAX_ROWS = gmpsc_pkg::DefaultMaxRows,
  parameter int MAX_COLS = gmpsc_pkg::DefaultMaxCols
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [3:0] cell_value
  input  wire logic                            in_tuser,   // [0] blocked
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [47:0]                          out_tdata,  // [11:0] best_score, [41:12] path_count
  input  wire logic                            cfg_we,
  input  wire logic [gmpsc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [gmpsc_pkg::DimW-1:0]      cfg_data
);

  localparam int RowW = $clog2(MAX_ROWS);
  localparam int ColW = $clog2(MAX_COLS);

  logic [gmpsc_pkg::DimW-1:0] grid_rows_r, grid_rows_nxt;
  logic [gmpsc_pkg::DimW-1:0] grid_cols_r, grid_cols_nxt;
  logic [RowW-1:0]            rows_last;
  logic [ColW-1:0]            cols_last;

  logic [RowW-1:0]            row_r, row_nxt;
  logic [ColW-1:0]            col_r, col_nxt;

  logic                       in_acc;
  gmpsc_pkg::tag_t            tag_in;

  logic                       v1_r, v1_nxt;
  gmpsc_pkg::tag_t            tag1_r;
  logic [3:0]                 val1_r;
  logic                       blk1_r;
  logic [ColW-1:0]            col1_r;
  logic                       s1_adv;
  logic                       s1_fire;

  gmpsc_pkg::nb_t             below_rd;
  gmpsc_pkg::nb_t             cell_res;
  gmpsc_pkg::nb_t             right_r, right_nxt;
  gmpsc_pkg::nb_t             diag_r, diag_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [gmpsc_pkg::ScoreW-1:0] out_score_r;
  logic [gmpsc_pkg::CountW-1:0] out_count_r;

  // Board dimensions with zero read as one and large values saturated.
  always_comb begin
    if (grid_rows_r == '0) begin
      rows_last = '0;
    end else if (int'(grid_rows_r) > MAX_ROWS) begin
      rows_last = RowW'(MAX_ROWS - 1);
    end else begin
      rows_last = RowW'(int'(grid_rows_r) - 1);
    end
    if (grid_cols_r == '0) begin
      cols_last = '0;
    end else if (int'(grid_cols_r) > MAX_COLS) begin
      cols_last = ColW'(MAX_COLS - 1);
    end else begin
      cols_last = ColW'(int'(grid_cols_r) - 1);
    end
  end

  always_comb begin
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    if (cfg_we) begin
      case (cfg_index)
        gmpsc_pkg::RegGridRows: grid_rows_nxt = cfg_data;
        gmpsc_pkg::RegGridCols: grid_cols_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv    = !tag1_r.last || !out_valid_r || out_tready;
  assign s1_fire   = v1_r && s1_adv;
  assign in_tready = !v1_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign tag_in.first = (row_r == '0) && (col_r == '0);
  assign tag_in.r_gt0 = (row_r != '0);
  assign tag_in.c_gt0 = (col_r != '0);
  assign tag_in.last  = (row_r == rows_last) && (col_r == cols_last);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_we) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (tag_in.last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (col_r == cols_last) begin
        row_nxt = row_r + RowW'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + ColW'(1);
      end
    end
  end

  always_comb begin
    v1_nxt = v1_r;
    if (in_acc) begin
      v1_nxt = 1'b1;
    end else if (s1_adv) begin
      v1_nxt = 1'b0;
    end
  end

  gmpsc_linebuf #(
    .Depth(MAX_COLS)
  ) u_linebuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc),
    .rd_addr(col_r),
    .wr_en  (s1_fire),
    .wr_addr(col1_r),
    .wr_data(cell_res),
    .rd_data(below_rd)
  );

  gmpsc_cell u_cell (
    .tag       (tag1_r),
    .cell_value(val1_r),
    .blocked   (blk1_r),
    .below     (below_rd),
    .right     (right_r),
    .diag      (diag_r),
    .res       (cell_res)
  );

  always_comb begin
    right_nxt = right_r;
    diag_nxt  = diag_r;
    if (cfg_we) begin
      right_nxt.reach = 1'b0;
      diag_nxt.reach  = 1'b0;
    end else if (s1_fire) begin
      right_nxt = cell_res;
      diag_nxt  = below_rd;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && tag1_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= gmpsc_pkg::GridRowsReset;
      grid_cols_r <= gmpsc_pkg::GridColsReset;
      row_r       <= '0;
      col_r       <= '0;
      v1_r        <= 1'b0;
      tag1_r      <= '0;
      right_r     <= '0;
      diag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      v1_r        <= v1_nxt;
      if (in_acc) begin
        tag1_r <= tag_in;
      end
      right_r     <= right_nxt;
      diag_r      <= diag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      val1_r <= in_tdata[3:0];
      blk1_r <= in_tuser;
      col1_r <= col_r;
    end
    if (s1_fire && tag1_r.last) begin
      out_score_r <= cell_res.score;
      out_count_r <= cell_res.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_count_r, out_score_r};

  `GMPSC_ASSERT(a_result_from_end_cell, $rose(out_tvalid) |-> $past(s1_fire && tag1_r.last), "result without end cell")
  `GMPSC_ASSERT(a_col_in_range, col_r <= cols_last || $past(cfg_we), "column position beyond board")
  `GMPSC_ASSERT(a_cfg_restarts, cfg_we |=> (row_r == '0 && col_r == '0), "board not restarted by write")
  `GMPSC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_tvalid && in_tready), "not idle after reset")

endmodule

`default_nettype wire

>>> test/grid_max_path_score_counter_tb.sv
// Self-checking testbench for the grid maximum-score path counter.
// A cell-level predictor computes the expected score and path count of each board.
// Depends only on gmpsc_pkg and the grid_max_path_score_counter top level.
`timescale 1ns / 1ps

module grid_max_path_score_counter_tb;

  typedef struct packed {
    logic [gmpsc_pkg::ScoreW-1:0] score;
    logic [gmpsc_pkg::CountW-1:0] count;
  } board_result_t;

  typedef enum {RxOpen, RxCoin, RxSparse} rx_mode_t;
  typedef enum {ValRandom, ValZero, ValNine, ValMixed} val_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [gmpsc_pkg::CfgIdxW-1:0] cfg_index = gmpsc_pkg::RegGridRows;
  logic [gmpsc_pkg::DimW-1:0] cfg_data = '0;

  // Predictor state.
  logic [gmpsc_pkg::DimW-1:0] board_rows = gmpsc_pkg::GridRowsReset;
  logic [gmpsc_pkg::DimW-1:0] board_cols = gmpsc_pkg::GridColsReset;
  logic [gmpsc_pkg::ScoreW-1:0] line_score [gmpsc_pkg::DefaultMaxCols];
  logic [gmpsc_pkg::CountW-1:0] line_count [gmpsc_pkg::DefaultMaxCols];
  bit line_reach [gmpsc_pkg::DefaultMaxCols];
  logic [gmpsc_pkg::ScoreW-1:0] prev_score = '0, diag_score = '0;
  logic [gmpsc_pkg::CountW-1:0] prev_count = '0, diag_count = '0;
  bit prev_reach = 1'b0, diag_reach = 1'b0;
  int row_pos = 0, col_pos = 0;

  board_result_t pending_results[$];
  int mismatches = 0;
  int cells_sent = 0;
  int burst_left = 0;
  bit gaps_enabled = 1'b1;
  int stall_cycles = 0;
  int rx_left = 0;
  rx_mode_t rx_mode = RxOpen;

  grid_max_path_score_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [3:0] cell_value
    .in_tuser   (in_tuser),   // [0] blocked
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [11:0] best_score, [41:12] path_count
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [gmpsc_pkg::DimW-1:0] v, input int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic void merge_neighbor(input bit ok, input logic [gmpsc_pkg::ScoreW-1:0] s,
                                         input logic [gmpsc_pkg::CountW-1:0] c,
                                         inout bit have,
                                         inout logic [gmpsc_pkg::ScoreW-1:0] best,
                                         inout logic [gmpsc_pkg::CountW-1:0] cnt);
    longint sum;
    if (!ok) return;
    if (!have || s > best) begin
      have = 1'b1;
      best = s;
      cnt = c;
    end else if (s == best) begin
      sum = longint'(cnt) + longint'(c);
      if (sum >= longint'(gmpsc_pkg::CountMod)) sum -= longint'(gmpsc_pkg::CountMod);
      cnt = sum[gmpsc_pkg::CountW-1:0];
    end
  endfunction

  function automatic void restart_board();
    row_pos = 0;
    col_pos = 0;
    prev_score = '0; prev_count = '0; prev_reach = 1'b0;
    diag_score = '0; diag_count = '0; diag_reach = 1'b0;
  endfunction

  function automatic void predict_cell(input logic [3:0] val, input logic blk);
    int rows, cols, r, c;
    bit have, reach;
    logic [gmpsc_pkg::ScoreW-1:0] best, old_s;
    logic [gmpsc_pkg::CountW-1:0] cnt, old_c;
    bit old_r;
    board_result_t res;
    rows = clamp_dim(board_rows, gmpsc_pkg::DefaultMaxRows);
    cols = clamp_dim(board_cols, gmpsc_pkg::DefaultMaxCols);
    r = row_pos;
    c = col_pos;
    have = 1'b0;
    best = '0;
    cnt = '0;
    old_s = line_score[c];
    old_c = line_count[c];
    old_r = line_reach[c];
    if (r == 0 && c == 0) begin
      have = 1'b1;
      cnt = gmpsc_pkg::CountW'(1);
    end else begin
      merge_neighbor(r > 0 && old_r, old_s, old_c, have, best, cnt);
      merge_neighbor(c > 0 && prev_reach, prev_score, prev_count, have, best, cnt);
      merge_neighbor(r > 0 && c > 0 && diag_reach, diag_score, diag_count, have, best, cnt);
    end
    reach = have && !blk;
    if (reach) begin
      best = best + gmpsc_pkg::ScoreW'(val);
    end else begin
      best = '0;
      cnt = '0;
    end
    line_score[c] = best;
    line_count[c] = cnt;
    line_reach[c] = reach;
    diag_score = old_s;
    diag_count = old_c;
    diag_reach = old_r;
    prev_score = best;
    prev_count = cnt;
    prev_reach = reach;
    if (r + 1 >= rows && c + 1 >= cols) begin
      res.score = best;
      res.count = cnt;
      pending_results = {pending_results, res};
      restart_board();
    end else if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = r + 1;
      prev_reach = 1'b0;
      diag_reach = 1'b0;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_cell(input logic [3:0] val, input logic blk);
    int gap;
    gap = 0;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, val};
    in_tuser <= blk;
    do @(posedge clk); while (!in_tready);
    predict_cell(val, blk);
    cells_sent++;
  endtask

  // Drops the request line and waits until every expected result has come out.
  task automatic settle_block();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_dim(input logic [gmpsc_pkg::CfgIdxW-1:0] idx,
                           input logic [gmpsc_pkg::DimW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == gmpsc_pkg::RegGridRows) board_rows = value;
    else board_cols = value;
    restart_board();
  endtask

  task automatic send_board(input int cells, input int block_pct, input val_mode_t value_mode);
    logic [3:0] val;
    for (int i = 0; i < cells; i++) begin
      case (value_mode)
        ValZero: val = 4'd0;
        ValNine: val = 4'd9;
        ValMixed: val = ($urandom_range(0, 1) != 0) ? 4'd9 : 4'd0;
        default: val = 4'($urandom_range(0, 9));
      endcase
      send_cell(val, $urandom_range(0, 99) < block_pct);
    end
  endtask

  task automatic test_reset_defaults();
    send_cell(4'd9, 1'b0);
    send_cell(4'd9, 1'b0);
    send_cell(4'd0, 1'b0);
    send_cell(4'd9, 1'b0);
    settle_block();
  endtask

  task automatic test_single_cell();
    write_dim(gmpsc_pkg::RegGridRows, 8'd0);
    write_dim(gmpsc_pkg::RegGridCols, 8'd0);
    send_cell(4'd9, 1'b0);
    send_cell(4'd5, 1'b1);
    settle_block();
  endtask

  task automatic test_unreachable();
    write_dim(gmpsc_pkg::RegGridRows, 8'd2);
    write_dim(gmpsc_pkg::RegGridCols, 8'd2);
    send_cell(4'd3, 1'b1);
    send_cell(4'd4, 1'b0);
    send_cell(4'd5, 1'b0);
    send_cell(4'd6, 1'b0);
    send_cell(4'd0, 1'b0);
    send_cell(4'd9, 1'b0);
    send_cell(4'd9, 1'b0);
    send_cell(4'd7, 1'b1);
    settle_block();
  endtask

  task automatic test_restart();
    write_dim(gmpsc_pkg::RegGridRows, 8'd3);
    write_dim(gmpsc_pkg::RegGridCols, 8'd3);
    send_cell(4'd9, 1'b0);
    send_cell(4'd9, 1'b0);
    settle_block();
    write_dim(gmpsc_pkg::RegGridCols, 8'd3);
    send_board(9, 0, ValZero);
    settle_block();
  endtask

  // With a 1x1 board every cell ends a board, so a long receiver stall backs up the input.
  task automatic test_pressure();
    write_dim(gmpsc_pkg::RegGridRows, 8'd1);
    write_dim(gmpsc_pkg::RegGridCols, 8'd1);
    gaps_enabled = 1'b0;
    stall_cycles = 200;
    send_board(12, 20, ValRandom);
    settle_block();
    write_dim(gmpsc_pkg::RegGridCols, 8'd3);
    stall_cycles = 150;
    send_board(15, 10, ValRandom);
    gaps_enabled = 1'b1;
    settle_block();
  endtask

  task automatic test_random_boards();
    int start, cells, pct;
    start = cells_sent;
    write_dim(gmpsc_pkg::RegGridRows, gmpsc_pkg::DimW'($urandom_range(0, 7)));
    write_dim(gmpsc_pkg::RegGridCols, gmpsc_pkg::DimW'($urandom_range(0, 7)));
    while (cells_sent - start < 40) begin
      if ($urandom_range(0, 3) == 0) begin
        settle_block();
        write_dim(gmpsc_pkg::RegGridRows, gmpsc_pkg::DimW'($urandom_range(0, 7)));
        write_dim(gmpsc_pkg::RegGridCols, gmpsc_pkg::DimW'($urandom_range(0, 7)));
      end
      cells = clamp_dim(board_rows, gmpsc_pkg::DefaultMaxRows) *
              clamp_dim(board_cols, gmpsc_pkg::DefaultMaxCols);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 35;
        default: pct = 10;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        send_board(int'($urandom_range(0, cells - 1)), pct, ValRandom);
        settle_block();
        write_dim(gmpsc_pkg::RegGridCols, board_cols);
      end else begin
        send_board(cells, pct, val_mode_t'($urandom_range(0, 3)));
      end
    end
    settle_block();
  endtask

  task automatic test_largest_boards();
    write_dim(gmpsc_pkg::RegGridRows, 8'd255);
    write_dim(gmpsc_pkg::RegGridCols, 8'd1);
    send_board(128, 0, ValMixed);
    settle_block();
    write_dim(gmpsc_pkg::RegGridRows, 8'd2);
    write_dim(gmpsc_pkg::RegGridCols, 8'd200);
    send_board(256, 2, ValRandom);
    settle_block();
    // An all-zero 14x14 board has more tied paths than the modulus.
    write_dim(gmpsc_pkg::RegGridRows, 8'd14);
    write_dim(gmpsc_pkg::RegGridCols, 8'd14);
    send_board(196, 0, ValZero);
    settle_block();
  endtask

  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      out_tready <= 1'b0;
      stall_cycles--;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(4, 40);
      end
      rx_left--;
      case (rx_mode)
        RxOpen: out_tready <= 1'b1;
        RxCoin: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_result
    board_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result score %0d count %0d",
                                  out_tdata[gmpsc_pkg::ScoreW-1:0],
                                  out_tdata[gmpsc_pkg::ScoreW +: gmpsc_pkg::CountW]));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[gmpsc_pkg::ScoreW-1:0] !== want.score)
          report_mismatch($sformatf("best_score %0d, expected %0d",
                                    out_tdata[gmpsc_pkg::ScoreW-1:0], want.score));
        if (out_tdata[gmpsc_pkg::ScoreW +: gmpsc_pkg::CountW] !== want.count)
          report_mismatch($sformatf("path_count %0d, expected %0d",
                                    out_tdata[gmpsc_pkg::ScoreW +: gmpsc_pkg::CountW],
                                    want.count));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < gmpsc_pkg::DefaultMaxCols; i++) begin
      line_score[i] = '0;
      line_count[i] = '0;
      line_reach[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_defaults();
    test_single_cell();
    test_unreachable();
    test_restart();
    test_pressure();
    test_random_boards();
    test_largest_boards();
    settle_block();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
